// ===== rtl/aesp_pkg.sv =====
package aesp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned EffectW = 2;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned ResultW = StatusW + EffectW + ColorW;
  localparam int unsigned OutDataW = ((ResultW + 7) / 8) * 8;

  localparam logic [ByteW-1:0] ChEsc   = 8'h1b;
  localparam logic [ByteW-1:0] ChOpen  = 8'h5b;  // '['
  localparam logic [ByteW-1:0] ChSemi  = 8'h3b;  // ';'
  localparam logic [ByteW-1:0] ChFinal = 8'h6d;  // 'm'
  localparam logic [ByteW-1:0] ChZero  = 8'h30;  // '0'
  localparam logic [ByteW-1:0] ChNine  = 8'h39;  // '9'

  localparam logic [ColorW-1:0] FgKeep  = 8'hf0;
  localparam logic [ColorW-1:0] BgKeep  = 8'h0f;
  localparam logic [ColorW-1:0] FgValid = 8'h08;
  localparam logic [ColorW-1:0] BgValid = 8'h80;

  localparam logic [ByteW-1:0] CodeReset    = 8'd0;
  localparam logic [ByteW-1:0] CodeBold     = 8'd1;
  localparam logic [ByteW-1:0] CodeUnder    = 8'd4;
  localparam logic [ByteW-1:0] CodeBlink    = 8'd5;
  localparam logic [ByteW-1:0] CodeStandout = 8'd7;
  localparam logic [ByteW-1:0] CodeNoColor  = 8'd100;
  localparam logic [ByteW-1:0] CodeFgDef    = 8'd39;
  localparam logic [ByteW-1:0] CodeBgDef    = 8'd49;
  localparam logic [ByteW-1:0] CodeFgLo     = 8'd30;
  localparam logic [ByteW-1:0] CodeFgHi     = 8'd37;
  localparam logic [ByteW-1:0] CodeBgLo     = 8'd40;
  localparam logic [ByteW-1:0] CodeBgHi     = 8'd47;

  localparam logic [ByteW-1:0] AccMax = 8'd255;

  typedef enum logic [StatusW-1:0] {
    ST_TEXT    = 3'd0,
    ST_HELD    = 3'd1,
    ST_ACCEPT  = 3'd2,
    ST_REJECT  = 3'd3,
    ST_RESTART = 3'd4
  } aesp_status_e;

  typedef enum logic [EffectW-1:0] {
    EF_NORMAL   = 2'd0,
    EF_BOLD     = 2'd1,
    EF_UNDER    = 2'd2,
    EF_STANDOUT = 2'd3
  } aesp_effect_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_ESC  = 2'd1,
    PH_BODY = 2'd2
  } aesp_phase_e;

  typedef struct packed {
    aesp_phase_e        phase;
    logic [EffectW-1:0] c_effect;
    logic [ColorW-1:0]  c_color;
    logic [EffectW-1:0] p_effect;
    logic [ColorW-1:0]  p_color;
    logic [ByteW-1:0]   acc;
    logic               have_digit;
    logic               stopped;
  } aesp_state_t;

endpackage

// ===== rtl/aesp_step.sv =====
module aesp_step
  import aesp_pkg::*;
(
  input  logic [ByteW-1:0] byte_i,
  input  logic             enable_i,
  input  aesp_state_t      state_i,
  output aesp_state_t      state_o,
  output aesp_status_e     status_o
);

  logic [11:0]        acc_ext;
  logic [ByteW-1:0]   digit;
  logic [ByteW-1:0]   acc_sat;
  logic [EffectW-1:0] code_effect;
  logic [ColorW-1:0]  code_color;
  logic [ByteW-1:0]   code_off;
  aesp_state_t        ended;
  logic               num_char;

  assign num_char = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign digit    = byte_i - ChZero;
  assign acc_ext  = {1'b0, state_i.acc, 3'b000} + {3'b000, state_i.acc, 1'b0}
                    + {4'b0000, digit};
  assign acc_sat  = (acc_ext > {4'b0000, AccMax}) ? AccMax : acc_ext[ByteW-1:0];

  // Apply one parameter code to the pending values.
  always_comb begin
    code_effect = state_i.p_effect;
    code_color  = state_i.p_color;
    code_off    = '0;
    case (state_i.acc)
      CodeReset: begin
        code_effect = EF_NORMAL;
        code_color  = '0;
      end
      CodeBold, CodeBlink: code_effect = EF_BOLD;
      CodeUnder:           code_effect = EF_UNDER;
      CodeStandout:        code_effect = EF_STANDOUT;
      CodeNoColor:         code_color  = '0;
      CodeFgDef:           code_color  = state_i.p_color & FgKeep;
      CodeBgDef:           code_color  = state_i.p_color & BgKeep;
      default: begin
        if (state_i.acc inside {[CodeFgLo:CodeFgHi]}) begin
          code_off   = state_i.acc - CodeFgLo;
          code_color = (state_i.p_color & FgKeep) | {5'b00000, code_off[2:0]} | FgValid;
        end else if (state_i.acc inside {[CodeBgLo:CodeBgHi]}) begin
          code_off   = state_i.acc - CodeBgLo;
          code_color = (state_i.p_color & BgKeep) | {1'b0, code_off[2:0], 4'b0000}
                       | BgValid;
        end
      end
    endcase
  end

  // End of a parameter; an empty one clears and stops the rest.
  always_comb begin
    ended = state_i;
    if (!state_i.stopped) begin
      if (!state_i.have_digit) begin
        ended.p_effect = EF_NORMAL;
        ended.p_color  = '0;
        ended.stopped  = 1'b1;
      end else begin
        ended.p_effect = code_effect;
        ended.p_color  = code_color;
      end
      ended.acc        = '0;
      ended.have_digit = 1'b0;
    end
  end

  always_comb begin
    state_o  = state_i;
    status_o = ST_TEXT;
    if (!enable_i) begin
      status_o      = ((state_i.phase == PH_ESC) || (state_i.phase == PH_BODY)) ?
                      ST_REJECT : ST_TEXT;
      state_o.phase = PH_IDLE;
    end else begin
      case (state_i.phase)
        PH_ESC: begin
          if (byte_i == ChOpen) begin
            status_o           = ST_HELD;
            state_o.phase      = PH_BODY;
            state_o.p_effect   = state_i.c_effect;
            state_o.p_color    = state_i.c_color;
            state_o.acc        = '0;
            state_o.have_digit = 1'b0;
            state_o.stopped    = 1'b0;
          end else if (byte_i == ChEsc) begin
            status_o = ST_RESTART;
          end else begin
            status_o      = ST_REJECT;
            state_o.phase = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (num_char) begin
            status_o = ST_HELD;
            if (!state_i.stopped) begin
              state_o.acc        = acc_sat;
              state_o.have_digit = 1'b1;
            end
          end else if (byte_i == ChSemi) begin
            state_o  = ended;
            status_o = ST_HELD;
          end else if (byte_i == ChFinal) begin
            state_o          = ended;
            state_o.c_effect = ended.p_effect;
            state_o.c_color  = ended.p_color;
            state_o.phase    = PH_IDLE;
            status_o         = ST_ACCEPT;
          end else if (byte_i == ChEsc) begin
            status_o      = ST_RESTART;
            state_o.phase = PH_ESC;
          end else begin
            status_o      = ST_REJECT;
            state_o.phase = PH_IDLE;
          end
        end
        default: begin
          if (byte_i == ChEsc) begin
            status_o      = ST_HELD;
            state_o.phase = PH_ESC;
          end else begin
            status_o      = ST_TEXT;
            state_o.phase = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/ansi_sgr_escape_parser_unit.sv =====
// Channel   Dir  tdata fields (low bit up)                 tuser/tlast
// s_axis    in   data_byte[7:0]                             none
// m_axis    out  status[2:0], effect[4:3], color[12:5], 0s  none
// cfg       in   enable (cfg_wdata_i), written on cfg_we_i  none
//
// One item per cycle while m_axis takes results; a result is valid on m_axis once
// its byte has passed the input register and then one pass of step logic into
// the result register. A stalled m_axis holds the result and a filled input
// register; an empty input register still takes a byte while only the result
// waits. Reset clears the parser state to idle with zero committed values and
// sets enable.
module ansi_sgr_escape_parser_unit
  import aesp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [ByteW-1:0]    s_axis_tdata_i,   // data_byte[7:0]
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // status[2:0] effect[4:3] color[12:5]
);

  logic             enable_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  aesp_state_t      state_q, state_d;
  aesp_status_e     step_status;
  logic             advance;
  logic             step;

  assign advance = !out_valid_q || m_axis_tready_i;
  assign step    = advance && in_valid_q;

  assign s_axis_tready_o = !in_valid_q || advance;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  aesp_step u_step (
    .byte_i   (in_byte_q),
    .enable_i (enable_q),
    .state_i  (state_q),
    .state_o  (state_d),
    .status_o (step_status)
  );

  assign out_data_d = {{(OutDataW-ResultW){1'b0}}, state_d.c_color, state_d.c_effect,
                       step_status};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b1;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '{phase: PH_IDLE, default: '0};
    end else begin
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
      if (s_axis_tready_o) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (step) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (step) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  a_commit_only_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && (step_status != ST_ACCEPT)
    |=> $stable(state_q.c_effect) && $stable(state_q.c_color))
    else $error("committed values changed without an accepted sequence");

  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_data_q[4:3] == state_q.c_effect)
                 && (out_data_q[12:5] == state_q.c_color))
    else $error("result effect/color differ from committed state");

  a_disable_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !enable_q |=> state_q.phase == PH_IDLE)
    else $error("phase not idle after a byte taken while disabled");

  a_held_keeps_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && ((step_status == ST_HELD) || (step_status == ST_RESTART))
    |=> state_q.phase != PH_IDLE)
    else $error("held byte left the parser idle");
`endif

endmodule

// ===== dv/tb_ansi_sgr_escape_parser_unit.sv =====
module tb_ansi_sgr_escape_parser_unit;
  import aesp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PadW        = OutDataW - ResultW;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned HoldAfter   = 150;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned SettleCycles = 8;

  localparam logic [ByteW-1:0] FixedCodes [8] = '{
    CodeReset, CodeBold, CodeUnder, CodeBlink,
    CodeStandout, CodeNoColor, CodeFgDef, CodeBgDef
  };

  typedef enum logic [1:0] {
    FEED_BYTE,
    FEED_ENABLE,
    FEED_DRAIN
  } feed_kind_e;

  typedef struct {
    feed_kind_e       kind;
    logic [ByteW-1:0] value;
  } feed_t;

  // Same layout as m_axis_tdata_o, lowest field last.
  typedef struct packed {
    logic [PadW-1:0]    pad;
    logic [ColorW-1:0]  color;
    logic [EffectW-1:0] effect;
    aesp_status_e       status;
  } sgr_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic                cfg_wdata_i = 1'b1;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [ByteW-1:0]    s_axis_tdata_i = '0;    // data_byte[7:0]
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;         // status[2:0] effect[4:3] color[12:5]

  ansi_sgr_escape_parser_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #2 clk_i = ~clk_i;

  // Parser state as the block should hold it.
  logic               sgr_enable = 1'b1;
  aesp_phase_e        sgr_phase = PH_IDLE;
  logic [EffectW-1:0] sgr_cur_effect = '0;
  logic [ColorW-1:0]  sgr_cur_color = '0;
  logic [EffectW-1:0] sgr_new_effect = '0;
  logic [ColorW-1:0]  sgr_new_color = '0;
  logic [ByteW-1:0]   sgr_number = '0;
  logic               sgr_have_digit = 1'b0;
  logic               sgr_stopped = 1'b0;

  feed_t       feed_q[$];
  sgr_result_t sgr_expect_q[$];
  int unsigned fed_bytes = 0;
  int unsigned results_seen = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;

  logic        in_taken = 1'b0;
  logic        out_taken = 1'b0;
  int unsigned src_gap = 0;
  logic        src_burst = 1'b0;
  int unsigned sink_wait = 0;
  int unsigned sink_hold = 0;
  logic        sink_hold_done = 1'b0;
  logic        sink_burst = 1'b0;

  // Close the current parameter; an empty one clears and stops the rest.
  function automatic void sgr_close_param();
    logic [ColorW-1:0] c;
    if (sgr_stopped) return;
    if (!sgr_have_digit) begin
      sgr_new_effect = EF_NORMAL;
      sgr_new_color  = '0;
      sgr_stopped    = 1'b1;
    end else begin
      c = sgr_new_color;
      case (sgr_number)
        CodeReset: begin
          sgr_new_effect = EF_NORMAL;
          c = '0;
        end
        CodeBold, CodeBlink: sgr_new_effect = EF_BOLD;
        CodeUnder:           sgr_new_effect = EF_UNDER;
        CodeStandout:        sgr_new_effect = EF_STANDOUT;
        CodeNoColor:         c = '0;
        CodeFgDef:           c = c & FgKeep;
        CodeBgDef:           c = c & BgKeep;
        default: begin
          if (sgr_number >= CodeFgLo && sgr_number <= CodeFgHi) begin
            c = (c & FgKeep) | (sgr_number - CodeFgLo) | FgValid;
          end else if (sgr_number >= CodeBgLo && sgr_number <= CodeBgHi) begin
            c = (c & BgKeep) | ((sgr_number - CodeBgLo) << 4) | BgValid;
          end
        end
      endcase
      sgr_new_color = c;
    end
    sgr_number     = '0;
    sgr_have_digit = 1'b0;
  endfunction

  function automatic sgr_result_t sgr_predict(logic [ByteW-1:0] b);
    sgr_result_t  r;
    aesp_status_e st;
    int unsigned  v;
    st = ST_TEXT;
    if (!sgr_enable) begin
      st = (sgr_phase == PH_ESC || sgr_phase == PH_BODY) ? ST_REJECT : ST_TEXT;
      sgr_phase = PH_IDLE;
    end else begin
      case (sgr_phase)
        PH_ESC: begin
          if (b == ChOpen) begin
            st = ST_HELD;
            sgr_phase      = PH_BODY;
            sgr_new_effect = sgr_cur_effect;
            sgr_new_color  = sgr_cur_color;
            sgr_number     = '0;
            sgr_have_digit = 1'b0;
            sgr_stopped    = 1'b0;
          end else if (b == ChEsc) begin
            st = ST_RESTART;
          end else begin
            st = ST_REJECT;
            sgr_phase = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (b >= ChZero && b <= ChNine) begin
            if (!sgr_stopped) begin
              v = int'(sgr_number) * 10 + int'(b - ChZero);
              sgr_number     = (v > int'(AccMax)) ? AccMax : v[ByteW-1:0];
              sgr_have_digit = 1'b1;
            end
            st = ST_HELD;
          end else if (b == ChSemi) begin
            sgr_close_param();
            st = ST_HELD;
          end else if (b == ChFinal) begin
            sgr_close_param();
            sgr_cur_effect = sgr_new_effect;
            sgr_cur_color  = sgr_new_color;
            st = ST_ACCEPT;
            sgr_phase = PH_IDLE;
          end else if (b == ChEsc) begin
            st = ST_RESTART;
            sgr_phase = PH_ESC;
          end else begin
            st = ST_REJECT;
            sgr_phase = PH_IDLE;
          end
        end
        default: begin
          if (b == ChEsc) begin
            st = ST_HELD;
            sgr_phase = PH_ESC;
          end else begin
            sgr_phase = PH_IDLE;
          end
        end
      endcase
    end
    r.pad    = '0;
    r.status = st;
    r.effect = sgr_cur_effect;
    r.color  = sgr_cur_color;
    return r;
  endfunction

  task automatic check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_cnt++;
    end
  endtask

  // Monitor: predict on every taken byte, check every result.
  always @(posedge clk_i or negedge rst_ni) begin
    sgr_result_t want;
    sgr_result_t got;
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= s_axis_tvalid_i && s_axis_tready_o;
      out_taken <= m_axis_tvalid_o && m_axis_tready_i;
      if (cfg_we_i) sgr_enable = cfg_wdata_i;
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sgr_expect_q.push_back(sgr_predict(s_axis_tdata_i));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        results_seen++;
        got = sgr_result_t'(m_axis_tdata_o);
        if (sgr_expect_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time,
                   m_axis_tdata_o);
          err_cnt++;
        end else begin
          want = sgr_expect_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("effect", want.effect, got.effect);
          check_field("color", want.color, got.color);
          check_field("pad", want.pad, got.pad);
        end
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
  end

  // Driver: offer queued bytes, apply enable writes once nothing is in flight.
  always @(negedge clk_i) begin
    feed_t            head;
    logic             nxt_valid;
    logic [ByteW-1:0] nxt_data;
    logic             nxt_we;
    logic             nxt_wdata;
    nxt_valid = s_axis_tvalid_i;
    nxt_data  = s_axis_tdata_i;
    nxt_we    = 1'b0;
    nxt_wdata = cfg_wdata_i;
    if (rst_ni) begin
      if (in_taken) begin
        nxt_valid = 1'b0;
        src_gap = src_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
      end
      if (!nxt_valid) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (feed_q.size() > 0) begin
          head = feed_q[0];
          case (head.kind)
            FEED_BYTE: begin
              nxt_valid = 1'b1;
              nxt_data  = head.value;
              void'(feed_q.pop_front());
            end
            FEED_ENABLE: begin
              if (sgr_expect_q.size() == 0) begin
                nxt_we    = 1'b1;
                nxt_wdata = head.value[0];
                void'(feed_q.pop_front());
              end
            end
            default: begin
              if (sgr_expect_q.size() == 0) void'(feed_q.pop_front());
            end
          endcase
        end
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_data;
    cfg_we_i        <= nxt_we;
    cfg_wdata_i     <= nxt_wdata;
  end

  // Receiver: random stalls per result, one long hold-off to back up the block.
  always @(negedge clk_i) begin
    logic nxt_ready;
    int unsigned w;
    nxt_ready = 1'b1;
    if (!rst_ni) begin
      nxt_ready = 1'b0;
    end else if (sink_hold > 0) begin
      sink_hold--;
      nxt_ready = 1'b0;
    end else if (!sink_hold_done && results_seen >= HoldAfter) begin
      sink_hold_done = 1'b1;
      sink_hold = HoldCycles - 1;
      nxt_ready = 1'b0;
    end else if (out_taken) begin
      w = sink_burst ? 0 : $urandom_range(0, 3);
      if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
      nxt_ready = (w == 0);
      sink_wait = (w > 0) ? w - 1 : 0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      nxt_ready = 1'b0;
    end
    m_axis_tready_i <= nxt_ready;
  end

  task automatic push_byte(logic [ByteW-1:0] b);
    feed_t f;
    f.kind  = FEED_BYTE;
    f.value = b;
    feed_q.push_back(f);
    fed_bytes++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_drain();
    feed_t f;
    f.kind  = FEED_DRAIN;
    f.value = '0;
    feed_q.push_back(f);
  endtask

  task automatic push_enable(logic en);
    feed_t f;
    f.kind  = FEED_ENABLE;
    f.value = {{(ByteW-1){1'b0}}, en};
    feed_q.push_back(f);
  endtask

  function automatic logic [ByteW-1:0] pick_color_code();
    return ($urandom_range(0, 1) == 0) ? CodeFgLo + ByteW'($urandom_range(0, 7))
                                       : CodeBgLo + ByteW'($urandom_range(0, 7));
  endfunction

  task automatic push_param();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      push_text($sformatf("%0d", FixedCodes[$urandom_range(0, 7)]));
    end else if (pick < 75) begin
      push_text($sformatf("%0d", pick_color_code()));
    end else if (pick < 83) begin
      push_text($sformatf("%0d", $urandom_range(0, 255)));
    end else if (pick < 88) begin
      // leave the parameter empty
    end else if (pick < 94) begin
      push_text($sformatf("%0d", $urandom_range(256, 99999)));
    end else begin
      push_text($sformatf("0%0d", pick_color_code()));
    end
  endtask

  task automatic push_random_burst();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      push_byte(ChEsc);
      push_byte(ChOpen);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++) begin
        if (i > 0) push_byte(ChSemi);
        push_param();
      end
      if (n > 0 && $urandom_range(0, 9) == 0) push_byte(ChSemi);
      push_byte(ChFinal);
    end else if (pick < 85) begin
      // cut a sequence short with a stray byte or a fresh ESC
      push_byte(ChEsc);
      if ($urandom_range(0, 2) != 0) begin
        push_byte(ChOpen);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) push_byte(ChSemi);
          push_param();
        end
      end
      push_byte(($urandom_range(0, 3) == 0) ? ChEsc : ByteW'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) push_byte(ByteW'($urandom_range(0, 255)));
    end
  endtask

  task automatic push_random_until(int unsigned total);
    while (fed_bytes < total) begin
      push_random_burst();
      if ($urandom_range(0, 39) == 0) push_drain();
    end
  endtask

  initial begin
    push_byte(8'h00);
    push_byte(8'hff);
    push_byte(ChEsc); push_text("[1;37;40m");
    // restart on ESC, saturating number, empty parameter stops the rest
    push_byte(ChEsc); push_byte(ChEsc); push_text("[999;;5m");
    push_byte(ChEsc); push_text("[m");
    push_byte(ChEsc); push_text("x");
    push_byte(ChEsc); push_text("[3"); push_byte(ChEsc);
    push_text("[7q");
    // disable while an ESC is held
    push_byte(ChEsc);
    push_enable(1'b0);
    push_text("A");
    push_enable(1'b1);

    push_random_until(fed_bytes + 300);
    push_enable(1'b0);
    push_random_until(fed_bytes + 100);
    push_enable(1'b1);
    push_random_until(fed_bytes + 300);
    push_enable(1'b0);
    push_random_until(fed_bytes + 60);
    push_enable(1'b1);
    push_random_until(fed_bytes + 80);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() != 0 || s_axis_tvalid_i || sgr_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (err_cnt == 0 && sgr_expect_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no item moved for %0d cycles", $time, StallLimit);
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/aesp_pkg.sv
rtl/aesp_step.sv
rtl/ansi_sgr_escape_parser_unit.sv
dv/tb_ansi_sgr_escape_parser_unit.sv
